FILE: rtl/core/psc_pkg.sv
// Shared types, register codes and helpers for the pressure sensor compensation core.
`timescale 1ns / 1ps

package psc_pkg;

   // Calibration register indexes, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_SENS      = 3'd0,
      REG_OFFS      = 3'd1,
      REG_SENS_TC   = 3'd2,
      REG_OFFS_TC   = 3'd3,
      REG_TREF      = 3'd4,
      REG_TEMP_COEF = 3'd5
   } reg_index_type;

   localparam int unsigned ADDR_W = 5;

   // Calibration words as held by the register file
   typedef struct packed {
      logic [15:0] c1;
      logic [15:0] c2;
      logic [15:0] c3;
      logic [15:0] c4;
      logic [15:0] c5;
      logic [15:0] c6;
   } cal_type;

   // Hand-over from the temperature / coefficient pipe to the pressure pipe
   typedef struct packed {
      logic                valid;
      logic                zero;
      logic [23:0]         raw_p;
      logic signed [39:0]  offs;
      logic signed [39:0]  sens;
      logic signed [20:0]  temp2;
   } stage_type;

   localparam logic signed [20:0] TEMP_BASE = 21'sd2000;

   // Signed shift right by k, rounding toward zero like a C division by 2**k
   function automatic logic signed [63:0] sdiv_pow2(logic signed [63:0] x, int unsigned k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

FILE: rtl/core/psc_regs.sv
// Calibration register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module psc_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [psc_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output psc_pkg::cal_type              cal
);
   import psc_pkg::*;

   cal_type       cal_ff, cal_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;

   // Decode the write transfer; indexes past the last register are dropped
   always_comb begin
      cal_in = cal_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SENS:      cal_in.c1 = pwdata[15:0];
            REG_OFFS:      cal_in.c2 = pwdata[15:0];
            REG_SENS_TC:   cal_in.c3 = pwdata[15:0];
            REG_OFFS_TC:   cal_in.c4 = pwdata[15:0];
            REG_TREF:      cal_in.c5 = pwdata[15:0];
            REG_TEMP_COEF: cal_in.c6 = pwdata[15:0];
            default:       cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // Read back the addressed word
   always_comb begin
      unique case (idx)
         REG_SENS:      prdata = {16'h0000, cal_ff.c1};
         REG_OFFS:      prdata = {16'h0000, cal_ff.c2};
         REG_SENS_TC:   prdata = {16'h0000, cal_ff.c3};
         REG_OFFS_TC:   prdata = {16'h0000, cal_ff.c4};
         REG_TREF:      prdata = {16'h0000, cal_ff.c5};
         REG_TEMP_COEF: prdata = {16'h0000, cal_ff.c6};
         default:       prdata = 32'h0000_0000;
      endcase
   end

   assign cal = cal_ff;

endmodule

FILE: rtl/core/psc_front.sv
// Temperature, offset and sensitivity pipe with the low-temperature correction.
`timescale 1ns / 1ps

module psc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [23:0]          raw_pressure,
   input  logic [23:0]          raw_temperature,
   input  psc_pkg::cal_type     cal,
   output psc_pkg::stage_type   out_stage
);
   import psc_pkg::*;

   // Stage A: temperature difference
   logic                valid_a_ff, valid_a_in;
   logic                zero_a_ff, zero_a_in;
   logic [23:0]         rawp_a_ff;
   logic signed [25:0]  dt_a_ff, dt_a_in;

   // Stage B: products of the temperature difference
   logic                valid_b_ff;
   logic                zero_b_ff;
   logic [23:0]         rawp_b_ff;
   logic signed [42:0]  m6_b_ff, m6_b_in;
   logic signed [42:0]  m4_b_ff, m4_b_in;
   logic signed [42:0]  m3_b_ff, m3_b_in;
   logic signed [51:0]  mdd_full;
   logic [47:0]         mdd_b_ff;

   // Stage C: first-order terms
   logic                valid_c_ff;
   logic                zero_c_ff;
   logic [23:0]         rawp_c_ff;
   logic                low_c_ff, low_c_in;
   logic signed [19:0]  q6_c_ff, q6_c_in;
   logic signed [20:0]  temp1_c_ff, temp1_c_in;
   logic signed [39:0]  offs_c_ff, offs_c_in;
   logic signed [39:0]  sens_c_ff, sens_c_in;
   logic [16:0]         tc_c_ff, tc_c_in;
   logic signed [36:0]  q4;
   logic signed [35:0]  q3;
   logic [51:0]         mdd11;

   // Stage D: square of the low-temperature excursion
   logic                valid_d_ff;
   logic                zero_d_ff;
   logic [23:0]         rawp_d_ff;
   logic                low_d_ff;
   logic signed [20:0]  temp1_d_ff;
   logic signed [39:0]  offs_d_ff;
   logic signed [39:0]  sens_d_ff;
   logic [16:0]         tc_d_ff;
   logic signed [39:0]  sq_full;
   logic [35:0]         sq_d_ff, sq_d_in;

   // Stage E: apply corrections
   logic                valid_e_ff;
   stage_type           out_e_ff, out_e_in;
   logic [40:0]         sq31;
   logic [41:0]         sq63;
   logic [37:0]         oc;
   logic [36:0]         sc;

   // Stage A logic
   always_comb begin
      valid_a_in = in_valid;
      zero_a_in  = (raw_pressure == 24'd0) || (raw_temperature == 24'd0);
      dt_a_in    = $signed({2'b00, raw_temperature}) - $signed({2'b00, cal.c5, 8'h00});
   end

   // Stage B logic
   always_comb begin
      m6_b_in  = dt_a_ff * $signed({1'b0, cal.c6});
      m4_b_in  = dt_a_ff * $signed({1'b0, cal.c4});
      m3_b_in  = dt_a_ff * $signed({1'b0, cal.c3});
      mdd_full = dt_a_ff * dt_a_ff;
   end

   // Stage C logic: truncating shifts, first-order sums, square term of temperature
   always_comb begin
      q6_c_in    = 20'(sdiv_pow2(64'(m6_b_ff), 23));
      q4         = 37'(sdiv_pow2(64'(m4_b_ff), 6));
      q3         = 36'(sdiv_pow2(64'(m3_b_ff), 7));
      temp1_c_in = TEMP_BASE + 21'(q6_c_in);
      low_c_in   = q6_c_in[19];
      offs_c_in  = $signed({7'b0, cal.c2, 17'b0}) + 40'(q4);
      sens_c_in  = $signed({8'b0, cal.c1, 16'b0}) + 40'(q3);
      mdd11      = ({4'b0, mdd_b_ff} << 3) + ({4'b0, mdd_b_ff} << 1) + {4'b0, mdd_b_ff};
      tc_c_in    = mdd11[51:35];
   end

   // Stage D logic
   always_comb begin
      sq_full = q6_c_ff * q6_c_ff;
      sq_d_in = sq_full[35:0];
   end

   // Stage E logic: subtract the corrections below the reference temperature
   always_comb begin
      sq31           = ({5'b0, sq_d_ff} << 5) - {5'b0, sq_d_ff};
      sq63           = ({6'b0, sq_d_ff} << 6) - {6'b0, sq_d_ff};
      oc             = sq31[40:3];
      sc             = sq63[41:5];
      out_e_in.valid = valid_d_ff;
      out_e_in.zero  = zero_d_ff;
      out_e_in.raw_p = rawp_d_ff;
      if (low_d_ff) begin
         out_e_in.offs  = offs_d_ff - $signed({2'b00, oc});
         out_e_in.sens  = sens_d_ff - $signed({3'b000, sc});
         out_e_in.temp2 = temp1_d_ff - $signed({4'b0000, tc_d_ff});
      end else begin
         out_e_in.offs  = offs_d_ff;
         out_e_in.sens  = sens_d_ff;
         out_e_in.temp2 = temp1_d_ff;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
         valid_e_ff <= out_e_in.valid;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      zero_a_ff      <= zero_a_in;
      rawp_a_ff      <= raw_pressure;
      dt_a_ff        <= dt_a_in;

      zero_b_ff      <= zero_a_ff;
      rawp_b_ff      <= rawp_a_ff;
      m6_b_ff        <= m6_b_in;
      m4_b_ff        <= m4_b_in;
      m3_b_ff        <= m3_b_in;
      mdd_b_ff       <= mdd_full[47:0];

      zero_c_ff      <= zero_b_ff;
      rawp_c_ff      <= rawp_b_ff;
      low_c_ff       <= low_c_in;
      q6_c_ff        <= q6_c_in;
      temp1_c_ff     <= temp1_c_in;
      offs_c_ff      <= offs_c_in;
      sens_c_ff      <= sens_c_in;
      tc_c_ff        <= tc_c_in;

      zero_d_ff      <= zero_c_ff;
      rawp_d_ff      <= rawp_c_ff;
      low_d_ff       <= low_c_ff;
      temp1_d_ff     <= temp1_c_ff;
      offs_d_ff      <= offs_c_ff;
      sens_d_ff      <= sens_c_ff;
      tc_d_ff        <= tc_c_ff;
      sq_d_ff        <= sq_d_in;

      out_e_ff       <= out_e_in;
   end

   // Hand over the payload with the reset valid bit
   always_comb begin
      out_stage       = out_e_ff;
      out_stage.valid = valid_e_ff;
   end

endmodule

FILE: rtl/core/psc_press.sv
// Pressure pipe: split wide multiply, truncating shifts and offset removal.
`timescale 1ns / 1ps

module psc_press (
   input  logic                 clock,
   input  logic                 reset,
   input  psc_pkg::stage_type   in_stage,
   output logic                 out_valid,
   output logic signed [31:0]   pressure_out,
   output logic signed [18:0]   temperature_out,
   output logic                 result_valid
);
   import psc_pkg::*;

   // Stage 1: partial products of raw pressure and sensitivity
   logic                valid_1_ff;
   logic                zero_1_ff;
   logic signed [39:0]  offs_1_ff;
   logic signed [20:0]  temp_1_ff;
   logic [43:0]         plo_1_ff, plo_1_in;
   logic signed [44:0]  phi_1_ff, phi_1_in;

   // Stage 2: full product
   logic                valid_2_ff;
   logic                zero_2_ff;
   logic signed [39:0]  offs_2_ff;
   logic signed [20:0]  temp_2_ff;
   logic signed [63:0]  prod_2_ff, prod_2_in;

   // Stage 3: scaled product less offset
   logic                valid_3_ff;
   logic                zero_3_ff;
   logic signed [20:0]  temp_3_ff;
   logic signed [42:0]  ps_3;
   logic signed [43:0]  diff_3_ff, diff_3_in;

   // Stage 4: output register
   logic                valid_4_ff;
   logic signed [31:0]  press_4_ff, press_4_in;
   logic signed [18:0]  temp_4_ff, temp_4_in;
   logic                rv_4_ff, rv_4_in;
   logic signed [28:0]  p29;

   // Stage 1 logic
   always_comb begin
      plo_1_in = {20'b0, in_stage.raw_p} * {24'b0, in_stage.sens[19:0]};
      phi_1_in = $signed({1'b0, in_stage.raw_p}) * $signed(in_stage.sens[39:20]);
   end

   // Stage 2 logic: recombine the halves
   always_comb begin
      prod_2_in = (64'(phi_1_ff) <<< 20) + $signed({20'b0, plo_1_ff});
   end

   // Stage 3 logic
   always_comb begin
      ps_3      = 43'(sdiv_pow2(prod_2_ff, 21));
      diff_3_in = 44'(ps_3) - 44'(offs_2_ff);
   end

   // Stage 4 logic: the scaled result spans 29 bits and is sign-extended to the output width
   always_comb begin
      p29 = 29'(sdiv_pow2(64'(diff_3_ff), 15));
      if (zero_3_ff) begin
         press_4_in = 32'sd0;
         temp_4_in  = 19'sd0;
         rv_4_in    = 1'b0;
      end else begin
         press_4_in = 32'(p29);
         temp_4_in  = temp_3_ff[18:0];
         rv_4_in    = 1'b1;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_1_ff <= 1'b0;
         valid_2_ff <= 1'b0;
         valid_3_ff <= 1'b0;
         valid_4_ff <= 1'b0;
      end else begin
         valid_1_ff <= in_stage.valid;
         valid_2_ff <= valid_1_ff;
         valid_3_ff <= valid_2_ff;
         valid_4_ff <= valid_3_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      zero_1_ff  <= in_stage.zero;
      offs_1_ff  <= in_stage.offs;
      temp_1_ff  <= in_stage.temp2;
      plo_1_ff   <= plo_1_in;
      phi_1_ff   <= phi_1_in;

      zero_2_ff  <= zero_1_ff;
      offs_2_ff  <= offs_1_ff;
      temp_2_ff  <= temp_1_ff;
      prod_2_ff  <= prod_2_in;

      zero_3_ff  <= zero_2_ff;
      temp_3_ff  <= temp_2_ff;
      diff_3_ff  <= diff_3_in;

      press_4_ff <= press_4_in;
      temp_4_ff  <= temp_4_in;
      rv_4_ff    <= rv_4_in;
   end

   assign out_valid       = valid_4_ff;
   assign pressure_out    = press_4_ff;
   assign temperature_out = temp_4_ff;
   assign result_valid    = rv_4_ff;

   // An item entering this pipe leaves after stage registers 1 to 4, and none is lost or invented
   a_latency_hit: assert property (@(posedge clock) disable iff (reset)
      in_stage.valid |-> ##4 out_valid)
      else $error("pressure pipe lost a transfer");

   a_latency_gap: assert property (@(posedge clock) disable iff (reset)
      !in_stage.valid |-> ##4 !out_valid)
      else $error("pressure pipe invented a transfer");

   // A zero reading gives an all-zero result
   a_zero_clear: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !result_valid) |-> (pressure_out == 32'sd0 && temperature_out == 19'sd0))
      else $error("rejected reading left non-zero result");

endmodule

FILE: rtl/core/pressure_sensor_compensation_core.sv
// Barometric pressure sensor compensation core: top level.
`timescale 1ns / 1ps
//
// Usage:
//  - Calibration words 1..6 are written through the APB-style port at byte
//    addresses 0x00..0x14; pready is always high, reads return the word.
//    Write them while no reading is in flight.
//  - A raw pressure / temperature pair is transferred at a clock edge with
//    start high and busy low. busy is always low: a new pair may follow in
//    every cycle.
//  - Each pair produces one result: rsp_valid is high for exactly one cycle
//    as the pair leaves the pipeline, with compensated pressure,
//    temperature and the rsp_result_valid flag. The receiver cannot stall;
//    the result must be taken in that cycle.
//  - Throughput is one pair per cycle over a nine-stage pipeline; the longest
//    stages hold one 26 x 26 multiply or one 25 x 20 partial product of the
//    split raw-pressure by sensitivity multiply.
//  - Synchronous reset clears the pipeline valid bits and sets every
//    calibration word to zero; no results appear until new transfers arrive.
//
module pressure_sensor_compensation_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [23:0]                  req_raw_pressure,
   input  logic [23:0]                  req_raw_temperature,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_pressure_out,
   output logic signed [18:0]           rsp_temperature_out,
   output logic                         rsp_result_valid,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [psc_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import psc_pkg::*;

   cal_type   cal;
   stage_type mid_stage;

   assign busy = 1'b0;

   // Calibration registers
   psc_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cal     (cal)
   );

   // Temperature and coefficient stages
   psc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (start && !busy),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .cal             (cal),
      .out_stage       (mid_stage)
   );

   // Pressure stages
   psc_press u_press (
      .clock           (clock),
      .reset           (reset),
      .in_stage        (mid_stage),
      .out_valid       (rsp_valid),
      .pressure_out    (rsp_pressure_out),
      .temperature_out (rsp_temperature_out),
      .result_valid    (rsp_result_valid)
   );

endmodule
